// ===== sv/lcru_pkg.sv =====
// ----------------------------------------------------------------------------
// lcru_pkg
// Shared constants and types for the lattice coefficient rounding unit:
// modulus, gamma2 choices, reciprocal multipliers and the opcode set.
// ----------------------------------------------------------------------------
package lcru_pkg;

  // Modulus and half modulus used for centring
  localparam int unsigned Q      = 8380417;
  localparam int unsigned HALF_Q = (Q - 1) / 2;

  // Field widths
  localparam int unsigned COEFF_W = 23;
  localparam int unsigned LOW_W   = 24;
  localparam int unsigned HIGH_W  = 10;
  localparam int unsigned OUTLO_W = 19;

  // Power-of-two rounding
  localparam int unsigned D_BITS = 13;

  // gamma2 choices and their doubled values
  localparam int unsigned GAMMA2_88 = (Q - 1) / 88;
  localparam int unsigned GAMMA2_32 = (Q - 1) / 32;
  localparam int unsigned TWO_G_88  = 2 * GAMMA2_88;
  localparam int unsigned TWO_G_32  = 2 * GAMMA2_32;

  // Reciprocal multipliers for the bucket estimate, applied to (a+127)>>7
  localparam int unsigned MUL_88 = 11275;
  localparam int unsigned MUL_32 = 1025;

  // Bucket counts less one
  localparam int unsigned TOP_88 = 43;
  localparam int unsigned TOP_32 = 15;

  typedef enum logic [1:0] {
    OP_POWER2ROUND = 2'd0,
    OP_DECOMPOSE   = 2'd1,
    OP_MAKE_HINT   = 2'd2,
    OP_USE_HINT    = 2'd3
  } opcode_t;

endpackage

// ===== sv/lattice_coefficient_rounding_unit.sv =====
// ----------------------------------------------------------------------------
// lattice_coefficient_rounding_unit
// Five-stage pipeline for power2round, decompose, make-hint and use-hint.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : request channel. in_tuser carries the opcode, in_tdata the
//           coefficient, low part, high part and hint bit.
//   out_* : result channel, one result per request, in request order.
//   cfg_* : gamma_mode, written with cfg_we while the unit is idle.
// Pipeline: a request passes through five register stages, and the last
//   is the output register that drives out_tvalid.
// Throughput: one request per cycle while out_tready is high. The rate
//   is set by the pipeline: the bucket reciprocal multiply, the bucket *
//   2*gamma2 product and the centring subtract each have a stage of their own.
// Reset: synchronous, active low. Clears all stage valid bits and sets
//   gamma_mode to 0 (gamma2 = (Q-1)/88).
// Stall: when out_tready is low the output holds; earlier stages keep
//   moving into empty slots, so in_tready stays high until the pipe is full.
// ----------------------------------------------------------------------------
module lattice_coefficient_rounding_unit
  import lcru_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // value_in[22:0], low_in[46:23], high_in[56:47],
                                 // hint_in[57], zero[63:58]
  input  logic [1:0]  in_tuser,  // opcode[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // high_out[9:0], low_out[28:10], hint_out[29],
                                 // zero[31:30]
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic gamma_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_mode_r <= 1'b0;
    end else if (cfg_we) begin
      gamma_mode_r <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its content moves on
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: reduce coefficient, make-hint compare
  // --------------------------------------------------------------------------
  logic [COEFF_W-1:0]      raw_val;
  logic signed [LOW_W-1:0] low_s;
  logic signed [LOW_W-1:0] g_s;
  logic                    hnz;

  logic [COEFF_W-1:0] s1_a_nxt, s1_a_r;
  logic               s1_mh_nxt, s1_mh_r;
  opcode_t            s1_op_r;
  logic               s1_hint_r;

  always_comb begin
    raw_val  = in_tdata[22:0];
    low_s    = $signed(in_tdata[46:23]);
    hnz      = (in_tdata[56:47] != '0);
    g_s      = gamma_mode_r ? $signed(LOW_W'(GAMMA2_32)) : $signed(LOW_W'(GAMMA2_88));
    // single conditional subtraction gives the standard representative
    s1_a_nxt = (raw_val >= COEFF_W'(Q)) ? (raw_val - COEFF_W'(Q)) : raw_val;
    // low part overflows into the high part
    s1_mh_nxt = (low_s > g_s) || (low_s < -g_s) || ((low_s == -g_s) && hnz);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a_r    <= s1_a_nxt;
      s1_mh_r   <= s1_mh_nxt;
      s1_op_r   <= opcode_t'(in_tuser);
      s1_hint_r <= in_tdata[57];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: power2round split, bucket reciprocal multiply
  // --------------------------------------------------------------------------
  logic [COEFF_W:0]         sum127;
  logic [16:0]              hi7;
  logic [13:0]              mul_k;
  logic [COEFF_W:0]         sum_p2;
  logic signed [COEFF_W:0]  p2_lo_full;

  logic [HIGH_W-1:0]        s2_p2hi_nxt, s2_p2hi_r;
  logic signed [OUTLO_W-1:0] s2_p2lo_nxt, s2_p2lo_r;
  logic [30:0]              s2_prod_nxt, s2_prod_r;
  logic [COEFF_W-1:0]       s2_a_r;
  logic                     s2_mh_r, s2_hint_r;
  opcode_t                  s2_op_r;

  always_comb begin
    sum_p2      = {1'b0, s1_a_r} + (COEFF_W+1)'((1 << (D_BITS - 1)) - 1);
    s2_p2hi_nxt = sum_p2[D_BITS +: HIGH_W];
    p2_lo_full  = $signed({1'b0, s1_a_r}) -
                  $signed({1'b0, s2_p2hi_nxt, {D_BITS{1'b0}}});
    s2_p2lo_nxt = p2_lo_full[OUTLO_W-1:0];
    // bucket estimate on (a+127)>>7
    sum127      = {1'b0, s1_a_r} + (COEFF_W+1)'(127);
    hi7         = sum127[23:7];
    mul_k       = gamma_mode_r ? 14'(MUL_32) : 14'(MUL_88);
    s2_prod_nxt = 31'(hi7) * 31'(mul_k);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_p2hi_r <= s2_p2hi_nxt;
      s2_p2lo_r <= s2_p2lo_nxt;
      s2_prod_r <= s2_prod_nxt;
      s2_a_r    <= s1_a_r;
      s2_mh_r   <= s1_mh_r;
      s2_hint_r <= s1_hint_r;
      s2_op_r   <= s1_op_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: round the product to a bucket index, wrap the top bucket
  // --------------------------------------------------------------------------
  logic [31:0] rnd32, rnd88;
  logic [7:0]  b88;
  logic [5:0]  s3_dhi_nxt, s3_dhi_r;

  logic [HIGH_W-1:0]         s3_p2hi_r;
  logic signed [OUTLO_W-1:0] s3_p2lo_r;
  logic [COEFF_W-1:0]        s3_a_r;
  logic                      s3_mh_r, s3_hint_r;
  opcode_t                   s3_op_r;

  always_comb begin
    rnd32 = {1'b0, s2_prod_r} + 32'(1 << 21);
    rnd88 = {1'b0, s2_prod_r} + 32'(1 << 23);
    b88   = rnd88[31:24];
    if (gamma_mode_r) begin
      s3_dhi_nxt = {2'b00, rnd32[25:22]};
    end else if (b88 > 8'(TOP_88)) begin
      s3_dhi_nxt = '0;
    end else begin
      s3_dhi_nxt = b88[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_dhi_r  <= s3_dhi_nxt;
      s3_p2hi_r <= s2_p2hi_r;
      s3_p2lo_r <= s2_p2lo_r;
      s3_a_r    <= s2_a_r;
      s3_mh_r   <= s2_mh_r;
      s3_hint_r <= s2_hint_r;
      s3_op_r   <= s2_op_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: low part a - hi * 2*gamma2
  // --------------------------------------------------------------------------
  logic [19:0]        two_g;
  logic [24:0]        hi_times_g;
  logic signed [24:0] s4_dlo_nxt, s4_dlo_r;

  logic [5:0]                s4_dhi_r;
  logic [HIGH_W-1:0]         s4_p2hi_r;
  logic signed [OUTLO_W-1:0] s4_p2lo_r;
  logic                      s4_mh_r, s4_hint_r;
  opcode_t                   s4_op_r;

  always_comb begin
    two_g      = gamma_mode_r ? 20'(TWO_G_32) : 20'(TWO_G_88);
    hi_times_g = 25'(s3_dhi_r) * 25'(two_g);
    s4_dlo_nxt = $signed({2'b00, s3_a_r}) - $signed(hi_times_g);
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_dlo_r  <= s4_dlo_nxt;
      s4_dhi_r  <= s3_dhi_r;
      s4_p2hi_r <= s3_p2hi_r;
      s4_p2lo_r <= s3_p2lo_r;
      s4_mh_r   <= s3_mh_r;
      s4_hint_r <= s3_hint_r;
      s4_op_r   <= s3_op_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: centre low part, apply hint, select result (output register)
  // --------------------------------------------------------------------------
  logic signed [24:0]        lo_c;
  logic [5:0]                hi_up, hi_dn, hi_fix;
  logic [HIGH_W-1:0]         s5_high_nxt, s5_high_r;
  logic signed [OUTLO_W-1:0] s5_low_nxt, s5_low_r;
  logic                      s5_hint_nxt, s5_hint_r;
  opcode_t                   s5_op_r;

  always_comb begin
    lo_c = (s4_dlo_r > $signed(25'(HALF_Q))) ? (s4_dlo_r - $signed(25'(Q))) : s4_dlo_r;
    // neighbouring bucket, wrapped round the bucket count
    if (gamma_mode_r) begin
      hi_up = {2'b00, s4_dhi_r[3:0] + 4'd1};
      hi_dn = {2'b00, s4_dhi_r[3:0] - 4'd1};
    end else begin
      hi_up = (s4_dhi_r == 6'(TOP_88)) ? 6'd0 : (s4_dhi_r + 6'd1);
      hi_dn = (s4_dhi_r == 6'd0) ? 6'(TOP_88) : (s4_dhi_r - 6'd1);
    end
    if (!s4_hint_r) begin
      hi_fix = s4_dhi_r;
    end else if (lo_c > 25'sd0) begin
      hi_fix = hi_up;
    end else begin
      hi_fix = hi_dn;
    end

    s5_high_nxt = '0;
    s5_low_nxt  = '0;
    s5_hint_nxt = 1'b0;
    case (s4_op_r)
      OP_POWER2ROUND: begin
        s5_high_nxt = s4_p2hi_r;
        s5_low_nxt  = s4_p2lo_r;
      end
      OP_DECOMPOSE: begin
        s5_high_nxt = HIGH_W'(s4_dhi_r);
        s5_low_nxt  = lo_c[OUTLO_W-1:0];
      end
      OP_MAKE_HINT: begin
        s5_hint_nxt = s4_mh_r;
      end
      OP_USE_HINT: begin
        s5_high_nxt = HIGH_W'(hi_fix);
      end
      default: begin
        s5_high_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_high_r <= s5_high_nxt;
      s5_low_r  <= s5_low_nxt;
      s5_hint_r <= s5_hint_nxt;
      s5_op_r   <= s4_op_r;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {2'b00, s5_hint_r, s5_low_r, s5_high_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // bucket index stays within the bucket count of the current mode
  a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (gamma_mode_r ? (s3_dhi_r <= 6'(TOP_32)) : (s3_dhi_r <= 6'(TOP_88))))
    else $error("decompose bucket out of range");

  // power2round low part lies in (-2^(D-1), 2^(D-1)]
  a_p2_low: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (s2_op_r == OP_POWER2ROUND)) |->
      ((s2_p2lo_r <= $signed(OUTLO_W'(1 << (D_BITS - 1)))) &&
       (s2_p2lo_r > -$signed(OUTLO_W'(1 << (D_BITS - 1))))))
    else $error("power2round low part out of range");

  // centred decompose low part is within gamma2
  a_dec_low: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && (s5_op_r == OP_DECOMPOSE)) |->
      (gamma_mode_r ?
        ((s5_low_r <= $signed(OUTLO_W'(GAMMA2_32))) &&
         (s5_low_r >= -$signed(OUTLO_W'(GAMMA2_32)))) :
        ((s5_low_r <= $signed(OUTLO_W'(GAMMA2_88))) &&
         (s5_low_r >= -$signed(OUTLO_W'(GAMMA2_88))))))
    else $error("decompose low part not centred");

  // a stalled result is never dropped by the pipe
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && !out_tready) |=> (v5_r && $stable(s5_high_r) && $stable(s5_low_r)))
    else $error("stalled result lost");

endmodule

// ===== verif/lattice_coefficient_rounding_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_coefficient_rounding_unit_tb
// Streams coefficient requests through the rounding unit and checks every
// result against a behavioural predictor that runs in the bench. The run
// opens with boundary requests and continues with random requests biased
// towards bucket and gamma2 edges. It covers both gamma2 modes, random
// idling on both channels, one long receiver hold-off and sender pauses.
// ----------------------------------------------------------------------------
module lattice_coefficient_rounding_unit_tb;
  import lcru_pkg::*;

  // Signed 64-bit copies of the package constants, so that centred
  // arithmetic never mixes with unsigned operands
  localparam longint MOD_Q   = longint'(Q);
  localparam longint HALF_QL = longint'(HALF_Q);
  localparam longint G88     = longint'(GAMMA2_88);
  localparam longint G32     = longint'(GAMMA2_32);
  localparam longint TWO88   = longint'(TWO_G_88);
  localparam longint TWO32   = longint'(TWO_G_32);
  localparam longint MUL88   = longint'(MUL_88);
  localparam longint MUL32   = longint'(MUL_32);
  localparam longint TOP88   = longint'(TOP_88);
  localparam longint TOP32   = longint'(TOP_32);

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_LEN       = 60;
  localparam int DRAIN_CYCLES   = 12;

  typedef struct packed {
    opcode_t     op;
    logic [22:0] value;
    logic [23:0] low;
    logic [9:0]  high;
    logic        hint;
  } coeff_req_t;

  typedef struct packed {
    logic [9:0]  high;
    logic [18:0] low;
    logic        hint;
  } coeff_res_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // value_in, low_in, high_in, hint_in, zero pad
  logic [1:0]  in_tuser   = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // high_out, low_out, hint_out, zero pad
  logic        cfg_we     = 1'b0;
  logic        cfg_wdata  = 1'b0;

  coeff_req_t coeff_requests[$];  // requests waiting for the driver
  coeff_res_t rounding_due[$];    // predicted results, oldest first
  coeff_req_t on_bus;
  coeff_res_t want;
  bit         gamma_shadow = 1'b0;
  int         tx_idle_pct  = 0;
  int         rx_idle_pct  = 0;
  int         hold_token   = 0;
  int         hold_seen    = 0;
  int         hold_left    = 0;
  int         quiet_cycles = 0;
  int         fail_count   = 0;

  lattice_coefficient_rounding_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bucket index and centred remainder of a reduced coefficient by 2*gamma2
  function automatic longint split_bucket(longint a, bit mode, output longint rem);
    longint hi;
    longint span;
    hi = (a + 127) >> 7;
    if (mode) begin
      hi   = ((hi * MUL32 + (longint'(1) << 21)) >> 22) & TOP32;
      span = TWO32;
    end else begin
      hi = (hi * MUL88 + (longint'(1) << 23)) >> 24;
      if (hi > TOP88) hi = 0;
      span = TWO88;
    end
    rem = a - hi * span;
    if (rem > HALF_QL) rem -= MOD_Q;
    return hi;
  endfunction

  // Expected result of one request under the given gamma2 mode
  function automatic coeff_res_t round_coefficient(coeff_req_t r, bit mode);
    longint     a;
    longint     hi;
    longint     lo;
    longint     g;
    coeff_res_t res;
    res = '0;
    hi  = 0;
    lo  = 0;
    g   = mode ? G32 : G88;
    a   = r.value;
    if (a >= MOD_Q) a -= MOD_Q;
    case (r.op)
      OP_POWER2ROUND: begin
        hi = (a + (longint'(1) << (D_BITS - 1)) - 1) >> D_BITS;
        lo = a - (hi << D_BITS);
      end
      OP_DECOMPOSE: begin
        hi = split_bucket(a, mode, lo);
      end
      OP_MAKE_HINT: begin
        lo = $signed(r.low);
        res.hint = (lo > g) || (lo < -g) || ((lo == -g) && (r.high != 0));
        lo = 0;
      end
      default: begin
        hi = split_bucket(a, mode, lo);
        if (r.hint) begin
          if (mode)
            hi = (lo > 0) ? ((hi + 1) & TOP32) : ((hi + TOP32) & TOP32);
          else if (lo > 0)
            hi = (hi == TOP88) ? 0 : hi + 1;
          else
            hi = (hi == 0) ? TOP88 : hi - 1;
        end
        lo = 0;
      end
    endcase
    res.high = hi[9:0];
    res.low  = lo[18:0];
    return res;
  endfunction

  function automatic coeff_req_t mk_request(opcode_t op, longint v, longint lo,
                                            longint hi, bit h);
    coeff_req_t r;
    r.op    = op;
    r.value = v[22:0];
    r.low   = lo[23:0];
    r.high  = hi[9:0];
    r.hint  = h;
    return r;
  endfunction

  // Random request, weighted towards rounding and gamma2 boundaries
  function automatic coeff_req_t random_request(bit mode);
    coeff_req_t r;
    longint     v;
    longint     lo;
    longint     g;
    int         pick;
    g    = mode ? G32 : G88;
    r.op = opcode_t'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0)
      v = $urandom_range(Q, (1 << COEFF_W) - 1);
    else if (pick <= 2)
      v = $urandom_range(0, mode ? 16 : 44) * 2 * g + $urandom_range(0, 8) - 4;
    else if (pick == 3)
      v = $urandom_range(0, 1023) * 8192 + 4095 + $urandom_range(0, 4) - 2;
    else
      v = $urandom_range(0, Q - 1);
    r.value = v[22:0];
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      lo = g + $urandom_range(0, 4) - 2;
      if ($urandom_range(0, 1)) lo = -lo;
    end else if (pick <= 6)
      lo = longint'($urandom_range(0, 2 * (Q - 1))) - (MOD_Q - 1);
    else
      lo = $urandom();
    r.low  = lo[23:0];
    r.high = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom());
    r.hint = $urandom_range(0, 1);
    return r;
  endfunction

  // Boundary requests for gamma2 = (Q-1)/88
  task automatic queue_directed();
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, 0, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, MOD_Q - 1, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, 4095, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, 4096, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, (1 << COEFF_W) - 1, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_POWER2ROUND, MOD_Q, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_DECOMPOSE, 0, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_DECOMPOSE, MOD_Q - 1, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_DECOMPOSE, TWO88, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_DECOMPOSE, G88, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_DECOMPOSE, (1 << COEFF_W) - 1, 0, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, G88, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, G88 + 1, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, -G88, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, -G88, 5, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, -G88 - 1, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, 24'h7FFFFF, 1023, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, 24'h800000, 0, 0));
    coeff_requests.push_back(mk_request(OP_MAKE_HINT, 0, 0, 1023, 0));
    coeff_requests.push_back(mk_request(OP_USE_HINT, MOD_Q - 1, 0, 0, 1));
    coeff_requests.push_back(mk_request(OP_USE_HINT, 0, 0, 0, 1));
    coeff_requests.push_back(mk_request(OP_USE_HINT, G88 + 1, 0, 0, 1));
    coeff_requests.push_back(mk_request(OP_USE_HINT, 100, 0, 0, 1));
    coeff_requests.push_back(mk_request(OP_USE_HINT, MOD_Q - 1, 0, 0, 0));
  endtask

  task automatic queue_random(int n);
    repeat (n) coeff_requests.push_back(random_request(gamma_shadow));
  endtask

  // Block until every request has gone in and every result has come out
  task automatic wait_drained();
    while (coeff_requests.size() != 0 || in_tvalid || rounding_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_gamma(bit mode);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gamma_shadow = mode;
  endtask

  // Request driver: predicts each request as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        rounding_due.push_back(round_coefficient(on_bus, gamma_shadow));
      if (!in_tvalid || in_tready) begin
        if (coeff_requests.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_bus = coeff_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, on_bus.hint, on_bus.high, on_bus.low, on_bus.value};
          in_tuser  <= on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result monitor: field-by-field compare against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (rounding_due.size() == 0) begin
        $display("%0t: result with none pending, got %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = rounding_due.pop_front();
        if (out_tdata[9:0] !== want.high) begin
          $display("%0t: high_out expected %0d got %0d", $time, want.high, out_tdata[9:0]);
          fail_count++;
        end
        if (out_tdata[28:10] !== want.low) begin
          $display("%0t: low_out expected %h got %h", $time, want.low, out_tdata[28:10]);
          fail_count++;
        end
        if (out_tdata[29] !== want.hint) begin
          $display("%0t: hint_out expected %0d got %0d", $time, want.hint, out_tdata[29]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL lattice_coefficient_rounding_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // gamma2 = (Q-1)/88 from reset; slow sender, busy receiver
    tx_idle_pct = 38;
    rx_idle_pct = 68;
    queue_directed();
    queue_random(130);
    wait_drained();

    // gamma2 = (Q-1)/32; idling the other way round
    write_gamma(1'b1);
    tx_idle_pct = 68;
    rx_idle_pct = 38;
    queue_random(130);
    wait_drained();

    // long receiver hold-off with the sender streaming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_token++;
    @(posedge clk);
    queue_random(24);
    wait_drained();

    // full rate in both modes
    write_gamma(1'b0);
    queue_random(60);
    wait_drained();
    write_gamma(1'b1);
    queue_random(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS lattice_coefficient_rounding_unit");
    else
      $display("FAIL lattice_coefficient_rounding_unit");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lcru_pkg.sv
sv/lattice_coefficient_rounding_unit.sv
verif/lattice_coefficient_rounding_unit_tb.sv
